[hdl/sled_pkg.sv]
// Shared definitions for the string literal escape decoder.
// Holds the command record passed from the front end to the back end,
// result codes, character constants and queue sizing. No dependencies.
package sled_pkg;

    // Command queue between the front end and the back end.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    // Leading part of a command: an octal flush unit or a hex replay.
    typedef enum logic [1:0] {
        PK_NONE,
        PK_UNIT,
        PK_REPLAY
    } t_pre_kind;

    // Main part of a command.
    typedef enum logic [1:0] {
        MK_NONE,
        MK_CP,
        MK_CLOSE,
        MK_ERR
    } t_main_kind;

    // Error codes as they appear on the result channel.
    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_LINE_END     = 3'd1,
        ERR_ESC_LINE_END = 3'd2,
        ERR_BAD_X        = 3'd3,
        ERR_BAD_U        = 3'd4,
        ERR_UNTERMINATED = 3'd5,
        ERR_BAD_START    = 3'd6
    } t_err;

    // One classified input item, expanded later into one or more beats.
    typedef struct packed {
        t_pre_kind  pre_kind;
        logic [15:0] pre_val;
        logic        rep_is_u;
        logic [1:0]  rep_cnt;
        logic [2:0]  rep_low;
        t_main_kind  main_kind;
        logic [20:0] main_cp;
        t_err        main_err;
    } t_cmd;

    // Source characters.
    localparam logic [20:0] CH_DQ = 21'h00_0022;
    localparam logic [20:0] CH_SQ = 21'h00_0027;
    localparam logic [20:0] CH_BSL = 21'h00_005C;
    localparam logic [20:0] CH_LF = 21'h00_000A;
    localparam logic [20:0] CH_CR = 21'h00_000D;
    localparam logic [20:0] CH_LS = 21'h00_2028;
    localparam logic [20:0] CH_PS = 21'h00_2029;
    localparam logic [20:0] CH_0 = 21'h00_0030;
    localparam logic [20:0] CH_7 = 21'h00_0037;
    localparam logic [20:0] CH_9 = 21'h00_0039;
    localparam logic [20:0] CH_UA = 21'h00_0041;
    localparam logic [20:0] CH_UF = 21'h00_0046;
    localparam logic [20:0] CH_LA = 21'h00_0061;
    localparam logic [20:0] CH_LB = 21'h00_0062;
    localparam logic [20:0] CH_LFF = 21'h00_0066;
    localparam logic [20:0] CH_LN = 21'h00_006E;
    localparam logic [20:0] CH_LR = 21'h00_0072;
    localparam logic [20:0] CH_LT = 21'h00_0074;
    localparam logic [20:0] CH_LU = 21'h00_0075;
    localparam logic [20:0] CH_LV = 21'h00_0076;
    localparam logic [20:0] CH_LX = 21'h00_0078;

    // Control units produced by the simple escapes.
    localparam logic [20:0] CU_BS = 21'h00_0008;
    localparam logic [20:0] CU_TAB = 21'h00_0009;
    localparam logic [20:0] CU_VT = 21'h00_000B;
    localparam logic [20:0] CU_FF = 21'h00_000C;

    // UTF-16 surrogate construction.
    localparam logic [20:0] CP_SUPP_BASE = 21'h01_0000;
    localparam logic [15:0] SURR_HI = 16'hD800;
    localparam logic [15:0] SURR_LO = 16'hDC00;

endpackage

[hdl/sled_ifs.sv]
// Channel interfaces of the string literal escape decoder.
// Input item, result item and configuration write channels.
// No dependencies.
interface sled_in_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        end_of_input;

    modport source(output valid, code_point, end_of_input, input ready);
    modport sink(input valid, code_point, end_of_input, output ready);
endinterface

interface sled_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        closed;
    logic [2:0]  error_code;
    logic        last;

    modport source(output valid, code_unit, unit_valid, closed, error_code, last,
                   input ready);
    modport sink(input valid, code_unit, unit_valid, closed, error_code, last,
                 output ready);
endinterface

interface sled_cfg_if;
    logic valid;
    logic ready;
    logic ext1_enabled;

    modport source(output valid, ext1_enabled, input ready);
    modport sink(input valid, ext1_enabled, output ready);
endinterface

[hdl/sled_front.sv]
// Front end of the string literal escape decoder: accepts source characters,
// tracks the literal's escape state and issues at most one command per item.
// Depends on sled_pkg.
module sled_front import sled_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [20:0] i_code_point,
    input  logic        i_end_of_input,
    input  logic        i_ext1,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_BODY = 3'd1;
    localparam logic [2:0] PH_BSL = 3'd2;
    localparam logic [2:0] PH_HEX = 3'd3;
    localparam logic [2:0] PH_OCT = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic        r_quote_dq, n_quote_dq;
    logic [15:0] r_esc_val, n_esc_val;
    logic [2:0]  r_dig_cnt, n_dig_cnt;
    logic        r_esc_is_u, n_esc_is_u;
    logic [2:0]  r_lower, n_lower;

    logic        w_accept;
    logic        w_is_lt;
    logic [20:0] w_quote;
    logic [4:0]  w_hex;
    logic        w_hex_ok;
    logic        w_oct_ok;
    logic [2:0]  w_need;
    logic [2:0]  w_cnt_inc;
    logic [15:0] w_hex_val;
    logic [15:0] w_oct_val;
    t_main_kind  w_body_kind;
    t_err        w_body_err;
    logic [2:0]  w_body_phase;
    t_cmd        w_cmd;

    // Hex digit decode: valid flag and value.
    function automatic logic [4:0] hex_digit(input logic [20:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b1, c[3:0]};
        end else if (c >= CH_LA && c <= CH_LFF) begin
            r = {1'b1, c[3:0] + 4'd9};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    assign w_accept = i_valid && !i_full;
    assign o_ready = !i_full;

    // Character classification shared by all phases.
    assign w_quote = r_quote_dq ? CH_DQ : CH_SQ;
    assign w_is_lt = (i_code_point == CH_LF) || (i_code_point == CH_CR) ||
                     (i_code_point == CH_LS) || (i_code_point == CH_PS);
    assign w_hex = hex_digit(i_code_point);
    assign w_hex_ok = !i_end_of_input && w_hex[4];
    assign w_oct_ok = !i_end_of_input && (i_code_point >= CH_0) && (i_code_point <= CH_7);
    assign w_need = r_esc_is_u ? 3'd4 : 3'd2;
    assign w_cnt_inc = r_dig_cnt + 3'd1;
    assign w_hex_val = {r_esc_val[11:0], w_hex[3:0]};
    assign w_oct_val = {r_esc_val[12:0], i_code_point[2:0]};

    // Plain literal text handling, also used after a flushed escape.
    always_comb begin
        w_body_err = ERR_NONE;
        priority if (i_end_of_input) begin
            w_body_kind = MK_ERR;
            w_body_err = ERR_UNTERMINATED;
            w_body_phase = PH_IDLE;
        end else if (i_code_point == w_quote) begin
            w_body_kind = MK_CLOSE;
            w_body_phase = PH_IDLE;
        end else if (w_is_lt) begin
            w_body_kind = MK_ERR;
            w_body_err = ERR_LINE_END;
            w_body_phase = PH_IDLE;
        end else if (i_code_point == CH_BSL) begin
            w_body_kind = MK_NONE;
            w_body_phase = PH_BSL;
        end else begin
            w_body_kind = MK_CP;
            w_body_phase = PH_BODY;
        end
    end

    // Phase sequencing and command build.
    always_comb begin
        n_phase = r_phase;
        n_quote_dq = r_quote_dq;
        n_esc_val = r_esc_val;
        n_dig_cnt = r_dig_cnt;
        n_esc_is_u = r_esc_is_u;
        n_lower = r_lower;
        w_cmd = '0;
        w_cmd.pre_kind = PK_NONE;
        w_cmd.main_kind = MK_NONE;
        w_cmd.main_err = ERR_NONE;
        w_cmd.main_cp = i_code_point;

        unique case (r_phase)
            PH_IDLE: begin
                if (!i_end_of_input && (i_code_point == CH_DQ || i_code_point == CH_SQ)) begin
                    n_quote_dq = (i_code_point == CH_DQ);
                    n_phase = PH_BODY;
                end else begin
                    w_cmd.main_kind = MK_ERR;
                    w_cmd.main_err = ERR_BAD_START;
                end
            end
            PH_BODY: begin
                w_cmd.main_kind = w_body_kind;
                w_cmd.main_err = w_body_err;
                n_phase = w_body_phase;
            end
            PH_BSL: begin
                if (i_end_of_input || w_is_lt) begin
                    w_cmd.main_kind = MK_ERR;
                    w_cmd.main_err = ERR_ESC_LINE_END;
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_BODY;
                    w_cmd.main_kind = MK_CP;
                    unique case (i_code_point)
                        CH_LB: w_cmd.main_cp = CU_BS;
                        CH_LT: w_cmd.main_cp = CU_TAB;
                        CH_LN: w_cmd.main_cp = CH_LF;
                        CH_LV: w_cmd.main_cp = CU_VT;
                        CH_LFF: w_cmd.main_cp = CU_FF;
                        CH_LR: w_cmd.main_cp = CH_CR;
                        CH_LX, CH_LU: begin
                            w_cmd.main_kind = MK_NONE;
                            n_phase = PH_HEX;
                            n_esc_is_u = (i_code_point == CH_LU);
                            n_esc_val = 16'd0;
                            n_dig_cnt = 3'd0;
                            n_lower = 3'd0;
                        end
                        default: begin
                            if (w_oct_ok) begin
                                w_cmd.main_kind = MK_NONE;
                                n_phase = PH_OCT;
                                n_esc_val = {13'd0, i_code_point[2:0]};
                                n_dig_cnt = 3'd1;
                            end
                        end
                    endcase
                end
            end
            PH_HEX: begin
                if (w_hex_ok) begin
                    if (r_dig_cnt < 3'd3 && i_code_point >= CH_LA) begin
                        n_lower[r_dig_cnt[1:0]] = 1'b1;
                    end
                    n_esc_val = w_hex_val;
                    n_dig_cnt = w_cnt_inc;
                    if (w_cnt_inc >= w_need) begin
                        w_cmd.main_kind = MK_CP;
                        w_cmd.main_cp = {5'd0, w_hex_val};
                        n_phase = PH_BODY;
                    end
                end else if (!i_ext1) begin
                    w_cmd.main_kind = MK_ERR;
                    w_cmd.main_err = r_esc_is_u ? ERR_BAD_U : ERR_BAD_X;
                    n_phase = PH_IDLE;
                end else begin
                    // Malformed escape is replayed, then the item is plain text.
                    w_cmd.pre_kind = PK_REPLAY;
                    w_cmd.pre_val = r_esc_val;
                    w_cmd.rep_is_u = r_esc_is_u;
                    w_cmd.rep_cnt = r_dig_cnt[1:0];
                    w_cmd.rep_low = r_lower;
                    w_cmd.main_kind = w_body_kind;
                    w_cmd.main_err = w_body_err;
                    n_phase = w_body_phase;
                end
            end
            PH_OCT: begin
                if (w_oct_ok) begin
                    n_esc_val = w_oct_val;
                    n_dig_cnt = w_cnt_inc;
                    if (w_cnt_inc >= 3'd3 || (w_cnt_inc == 3'd2 && w_oct_val >= 16'd32)) begin
                        w_cmd.main_kind = MK_CP;
                        w_cmd.main_cp = {5'd0, w_oct_val};
                        n_phase = PH_BODY;
                    end
                end else begin
                    // A non-octal character ends the escape and is plain text.
                    w_cmd.pre_kind = PK_UNIT;
                    w_cmd.pre_val = r_esc_val;
                    w_cmd.main_kind = w_body_kind;
                    w_cmd.main_err = w_body_err;
                    n_phase = w_body_phase;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;
    assign o_push = w_accept &&
                    (w_cmd.pre_kind != PK_NONE || w_cmd.main_kind != MK_NONE);

    // Escape state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_quote_dq <= 1'b0;
            r_esc_val <= 16'd0;
            r_dig_cnt <= 3'd0;
            r_esc_is_u <= 1'b0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_quote_dq <= n_quote_dq;
            r_esc_val <= n_esc_val;
            r_dig_cnt <= n_dig_cnt;
            r_esc_is_u <= n_esc_is_u;
        end
    end

    // Letter-case flags of the hex digits, written before they are read.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lower <= n_lower;
        end
    end

endmodule

[hdl/sled_queue.sv]
// Command queue between the front end and the back end of the decoder.
// A small register FIFO of t_cmd records. Depends on sled_pkg.
module sled_queue import sled_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head = r_mem[r_rd_ptr];

    // Storage is written on push only; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

[hdl/sled_back.sv]
// Back end of the decoder: expands the queue head command into result beats
// (replays, surrogate pairs), one per cycle while i_ready is high. Depends on sled_pkg.
module sled_back import sled_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_empty,
    input  logic        i_ready,
    output logic        o_valid,
    output logic        o_pop,
    output logic [15:0] o_code_unit,
    output logic        o_unit_valid,
    output logic        o_closed,
    output logic [2:0]  o_error_code,
    output logic        o_last
);

    logic [2:0]  r_step;
    logic [2:0]  w_npre;
    logic [2:0]  w_nmain;
    logic [2:0]  w_ntot;
    logic [2:0]  w_m;
    logic        w_supp;
    logic [20:0] w_v;
    logic [1:0]  w_i;
    logic [1:0]  w_sh;
    logic [3:0]  w_d;
    logic        w_low;
    logic [15:0] w_digit_ch;
    logic        w_beat;

    assign o_valid = !i_empty;
    assign w_beat = o_valid && i_ready;
    assign o_pop = w_beat && o_last;

    // Beat counts of the leading and main parts.
    assign w_supp = (i_cmd.main_cp >= CP_SUPP_BASE);
    always_comb begin
        unique case (i_cmd.pre_kind)
            PK_UNIT: w_npre = 3'd1;
            PK_REPLAY: w_npre = 3'd1 + {1'b0, i_cmd.rep_cnt};
            default: w_npre = 3'd0;
        endcase
        unique case (i_cmd.main_kind)
            MK_CP: w_nmain = w_supp ? 3'd2 : 3'd1;
            MK_CLOSE, MK_ERR: w_nmain = 3'd1;
            default: w_nmain = 3'd0;
        endcase
    end
    assign w_ntot = w_npre + w_nmain;
    assign w_m = r_step - w_npre;
    assign o_last = (r_step == w_ntot - 3'd1);

    // Surrogate split of a supplementary code point.
    assign w_v = i_cmd.main_cp - CP_SUPP_BASE;

    // Replayed hex digit for the current beat.
    assign w_i = r_step[1:0] - 2'd1;
    assign w_sh = i_cmd.rep_cnt - 2'd1 - w_i;
    always_comb begin
        unique case (w_sh)
            2'd0: w_d = i_cmd.pre_val[3:0];
            2'd1: w_d = i_cmd.pre_val[7:4];
            2'd2: w_d = i_cmd.pre_val[11:8];
            default: w_d = i_cmd.pre_val[15:12];
        endcase
        unique case (w_i)
            2'd0: w_low = i_cmd.rep_low[0];
            2'd1: w_low = i_cmd.rep_low[1];
            2'd2: w_low = i_cmd.rep_low[2];
            default: w_low = 1'b0;
        endcase
        if (w_d < 4'd10) begin
            w_digit_ch = CH_0[15:0] + {12'd0, w_d};
        end else begin
            w_digit_ch = (w_low ? CH_LA[15:0] : CH_UA[15:0]) + {12'd0, w_d} - 16'd10;
        end
    end

    // Result payload of the current beat.
    always_comb begin
        o_code_unit = 16'd0;
        o_unit_valid = 1'b0;
        o_closed = 1'b0;
        o_error_code = ERR_NONE;
        if (r_step < w_npre) begin
            o_unit_valid = 1'b1;
            if (i_cmd.pre_kind == PK_UNIT) begin
                o_code_unit = i_cmd.pre_val;
            end else if (r_step == 3'd0) begin
                o_code_unit = i_cmd.rep_is_u ? CH_LU[15:0] : CH_LX[15:0];
            end else begin
                o_code_unit = w_digit_ch;
            end
        end else begin
            unique case (i_cmd.main_kind)
                MK_CP: begin
                    o_unit_valid = 1'b1;
                    if (!w_supp) begin
                        o_code_unit = i_cmd.main_cp[15:0];
                    end else if (w_m == 3'd0) begin
                        o_code_unit = SURR_HI | {6'd0, w_v[19:10]};
                    end else begin
                        o_code_unit = SURR_LO | {6'd0, w_v[9:0]};
                    end
                end
                MK_CLOSE: o_closed = 1'b1;
                MK_ERR: o_error_code = i_cmd.main_err;
                default: o_closed = 1'b0;
            endcase
        end
    end

    // Beat counter within the head command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
        end else if (o_pop) begin
            r_step <= 3'd0;
        end else if (w_beat) begin
            r_step <= r_step + 3'd1;
        end
    end

endmodule

[hdl/string_literal_escape_decoder_unit.sv]
// String literal escape decoder, top level: one code point in per beat,
// a quoted literal's value out as UTF-16 code units. Uses sled_pkg,
// sled_ifs, sled_front, sled_queue and sled_back.
//
// The block accepts one source character per cycle whenever its four-entry
// command queue has room; the front end classifies each character the cycle
// it arrives, and the back end plays out its results one beat per cycle while
// the result channel is ready, the first one once the item's command reaches
// the queue head. An item gives zero to six result beats (a replayed malformed
// escape plus a surrogate pair is the longest), and the front end can take new
// items while earlier ones still play out. The last beat of every item
// carries last. The single configuration register (ext1_enabled, which turns
// malformed \x and \u escapes into literal text) is always ready and should
// be written only while no item is in flight.
module string_literal_escape_decoder_unit import sled_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sled_in_if.sink       i_item,
    sled_cfg_if.sink      i_cfg,
    sled_out_if.source    o_result
);

    logic r_ext1;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_cmd;
    t_cmd w_head;

    // Configuration register.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext1 <= 1'b0;
        end else if (i_cfg.valid) begin
            r_ext1 <= i_cfg.ext1_enabled;
        end
    end

    // Front end: classification and escape tracking.
    sled_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_item.valid),
        .o_ready        (i_item.ready),
        .i_code_point   (i_item.code_point),
        .i_end_of_input (i_item.end_of_input),
        .i_ext1         (r_ext1),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_cmd          (w_cmd)
    );

    // Command queue.
    sled_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Back end: beat expansion.
    sled_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_head),
        .i_empty      (w_empty),
        .i_ready      (o_result.ready),
        .o_valid      (o_result.valid),
        .o_pop        (w_pop),
        .o_code_unit  (o_result.code_unit),
        .o_unit_valid (o_result.unit_valid),
        .o_closed     (o_result.closed),
        .o_error_code (o_result.error_code),
        .o_last       (o_result.last)
    );

    // Reset empties the queue, so no beat is offered right after it.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result offered right after reset");

    // A close or an error always ends the item's results.
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.closed || o_result.error_code != ERR_NONE)
        |-> o_result.last)
        else $error("close or error beat without last");

    // A beat carries a unit, a close or an error, never two of them.
    a_beat_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.unit_valid
        |-> !o_result.closed && o_result.error_code == ERR_NONE)
        else $error("unit beat also flags close or error");

    // A popped command frees a slot, so the front end can take an item next.
    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && !w_push |=> !w_full)
        else $error("queue still full after a pop");

endmodule
